FILE: hdl/bmhq_pkg.sv
// Shared types, codes and sizes for the binary min heap queue.
package bmhq_pkg;

    localparam int CAPACITY = 64;
    localparam int KEY_W    = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int STAT_W   = 2;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 48;

    typedef logic signed [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0]        count_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NOP   = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RSVD  = 2'd3
    } status_t;

    // Command broadcast to every cell of the sorted chain.
    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

FILE: hdl/bmhq_cell.sv
// One cell of the sorted key chain: holds a key and shifts with its neighbours.
module bmhq_cell (
    input  logic                clk,
    input  bmhq_pkg::cell_ctrl_t ctrl,
    input  bmhq_pkg::key_t      key,
    input  logic                occupied,
    input  bmhq_pkg::key_t      left_value,
    input  logic                left_gt,
    input  bmhq_pkg::key_t      right_value,
    output bmhq_pkg::key_t      value,
    output bmhq_pkg::key_t      value_next,
    output logic                gt
);

    bmhq_pkg::key_t value_reg;

    // An empty cell behaves as an infinitely large key, so the new key lands
    // at the first cell whose key exceeds it.
    assign gt = !occupied || (value_reg > key);

    always_comb
    begin
        priority if (ctrl.push && gt)
        begin
            value_next = left_gt ? left_value : key;
        end
        else if (ctrl.pop)
        begin
            value_next = right_value;
        end
        else
        begin
            value_next = value_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: hdl/binary_min_heap_queue.sv
// Top level of the min-priority queue built as a sorted chain of key cells.
//
// Input channel s_axis: one transaction per command. tuser carries the
// operation (push, pop, clear), tdata the signed key used by a push.
// Output channel m_axis: exactly one result transaction per command, holding
// the smallest key, the empty flag, the entry count and a status code.
// A push to a full queue is dropped with status full; a pop from an empty
// queue changes nothing and reports status empty; clear empties the queue.
// Every cell compares its key with the incoming one in parallel, so a command
// is applied to the whole chain at once: the result is registered and appears on
// m_axis in the cycle after the command is accepted, and one command per cycle is
// sustained while the receiver keeps up.
// The output register decouples the two sides: a new command is accepted
// whenever the result register is empty or is being taken in the same cycle.
// When the receiver stalls, the result holds and s_axis_tready drops.
// Reset empties the queue and the output register; key storage needs no
// clearing since only occupied cells are ever read.
module binary_min_heap_queue (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [31:0] value
    input  logic [1:0]  s_axis_tuser,  // [1:0] op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] top_value, [32] empty_res, [39:33] count, [41:40] status, rest zero
    output logic [47:0] m_axis_tdata
);

    localparam int N = bmhq_pkg::CAPACITY;

    bmhq_pkg::count_t     count_reg, count_next;
    logic                 m_valid_reg;
    bmhq_pkg::key_t       top_reg, top_next;
    logic                 empty_reg, empty_next;
    bmhq_pkg::count_t     out_count_reg;
    bmhq_pkg::status_t    status_reg, status_next;

    bmhq_pkg::cell_ctrl_t ctrl;
    bmhq_pkg::key_t       key;
    bmhq_pkg::op_t        op;
    logic                 accept;
    logic                 full;
    logic                 is_empty;

    bmhq_pkg::key_t       cell_value [N];
    bmhq_pkg::key_t       cell_next  [N];
    logic [N-1:0]         cell_gt;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign op            = bmhq_pkg::op_t'(s_axis_tuser);
    assign key           = bmhq_pkg::key_t'(s_axis_tdata);
    assign full          = (count_reg == bmhq_pkg::count_t'(N));
    assign is_empty      = (count_reg == '0);

    always_comb
    begin
        ctrl        = '{push: 1'b0, pop: 1'b0};
        count_next  = count_reg;
        status_next = bmhq_pkg::ST_OK;
        unique case (op)
            bmhq_pkg::OP_PUSH:
            begin
                if (full)
                begin
                    status_next = bmhq_pkg::ST_FULL;
                end
                else
                begin
                    ctrl.push  = accept;
                    count_next = count_reg + bmhq_pkg::count_t'(1);
                end
            end
            bmhq_pkg::OP_POP:
            begin
                if (is_empty)
                begin
                    status_next = bmhq_pkg::ST_EMPTY;
                end
                else
                begin
                    ctrl.pop   = accept;
                    count_next = count_reg - bmhq_pkg::count_t'(1);
                end
            end
            bmhq_pkg::OP_CLEAR:
            begin
                count_next = '0;
            end
            default:
            begin
                count_next = count_reg;
            end
        endcase
    end

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_cell
            bmhq_pkg::key_t left_value;
            bmhq_pkg::key_t right_value;
            logic           left_gt;

            if (i == 0)
            begin : g_first
                assign left_value = key;
                assign left_gt    = 1'b0;
            end
            else
            begin : g_mid
                assign left_value = cell_value[i-1];
                assign left_gt    = cell_gt[i-1];
            end

            if (i == N - 1)
            begin : g_last
                assign right_value = cell_value[i];
            end
            else
            begin : g_inner
                assign right_value = cell_value[i+1];
            end

            bmhq_cell u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .key         (key),
                .occupied    (count_reg > bmhq_pkg::count_t'(i)),
                .left_value  (left_value),
                .left_gt     (left_gt),
                .right_value (right_value),
                .value       (cell_value[i]),
                .value_next  (cell_next[i]),
                .gt          (cell_gt[i])
            );
        end
    endgenerate

    assign empty_next = (count_next == '0);
    assign top_next   = empty_next ? '0 : cell_next[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            top_reg       <= top_next;
            empty_reg     <= empty_next;
            out_count_reg <= count_next;
            status_reg    <= status_next;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {6'd0, status_reg, out_count_reg, empty_reg, top_reg};

endmodule

FILE: hdl/bmhq_checker.sv
// Port-level checks for the min-priority queue and their binding.
module bmhq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    logic [31:0] res_top;
    logic        res_empty;
    logic [6:0]  res_count;
    logic [1:0]  res_status;

    assign res_top    = m_axis_tdata[31:0];
    assign res_empty  = m_axis_tdata[32];
    assign res_count  = m_axis_tdata[39:33];
    assign res_status = m_axis_tdata[41:40];

    // A stalled result must not change under the receiver.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (res_empty == (res_count == 7'd0))
                          && (!res_empty || res_top == 32'd0))
        else $error("empty flag, count and top value disagree");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res_status == bmhq_pkg::ST_FULL
        |-> res_count == 7'(bmhq_pkg::CAPACITY))
        else $error("dropped push reported below capacity");

    a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res_status == bmhq_pkg::ST_EMPTY |-> res_empty)
        else $error("ignored pop reported on a non-empty queue");

    // A clear command always yields an empty queue with status ok.
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == bmhq_pkg::OP_CLEAR
        |=> m_axis_tvalid && res_empty && res_status == bmhq_pkg::ST_OK)
        else $error("clear did not empty the queue");

endmodule

bind binary_min_heap_queue bmhq_checker u_bmhq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/bmhq_checker.sv
`timescale 1ns / 1ps
// Watches both streams of the min heap queue, predicts every result and compares it.
module bmhq_scoreboard
    import bmhq_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    output int          error_count,
    output int          pending_results
);

    localparam int PRINT_CAP = 50;

    typedef struct packed {
        status_t status;
        count_t  count;
        logic    empty;
        key_t    top;
    } heap_result_t;

    key_t         heap_keys [CAPACITY];
    int           held_count;
    heap_result_t expected_q [$];
    heap_result_t want;
    heap_result_t next_result;

    initial
    begin
        error_count     = 0;
        pending_results = 0;
        held_count      = 0;
    end

    task automatic report_mismatch(input string what, input longint got, input longint wanted);
        error_count++;
        if (error_count <= PRINT_CAP)
        begin
            $display("ERROR at %0t: %s is %0d, expected %0d", $time, what, got, wanted);
        end
    endtask

    // Applies one command to the shadow heap and returns the result it yields.
    function automatic heap_result_t apply_command(input op_t op, input key_t key);
        heap_result_t r;
        int           slot;
        int           parent;
        int           child;
        logic         sifting;
        key_t         moved;
        r.status = ST_OK;
        case (op)
            OP_PUSH:
            begin
                if (held_count >= CAPACITY)
                begin
                    r.status = ST_FULL;
                end
                else
                begin
                    slot    = held_count;
                    sifting = 1'b1;
                    while (sifting && slot > 0)
                    begin
                        parent = (slot - 1) / 2;
                        if (heap_keys[parent] <= key)
                        begin
                            sifting = 1'b0;
                        end
                        else
                        begin
                            heap_keys[slot] = heap_keys[parent];
                            slot            = parent;
                        end
                    end
                    heap_keys[slot] = key;
                    held_count++;
                end
            end
            OP_POP:
            begin
                if (held_count == 0)
                begin
                    r.status = ST_EMPTY;
                end
                else
                begin
                    held_count--;
                    moved   = heap_keys[held_count];
                    slot    = 0;
                    sifting = 1'b1;
                    while (sifting && 2 * slot + 1 < held_count)
                    begin
                        child = 2 * slot + 1;
                        // On a tie between the children the left one is taken.
                        if (child + 1 < held_count && heap_keys[child] > heap_keys[child + 1])
                        begin
                            child++;
                        end
                        if (moved > heap_keys[child])
                        begin
                            heap_keys[slot] = heap_keys[child];
                            slot            = child;
                        end
                        else
                        begin
                            sifting = 1'b0;
                        end
                    end
                    heap_keys[slot] = moved;
                end
            end
            OP_CLEAR:
            begin
                held_count = 0;
            end
            default:
            begin
            end
        endcase
        r.count = count_t'(held_count);
        r.empty = (held_count == 0);
        r.top   = (held_count > 0) ? heap_keys[0] : key_t'(0);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count = 0;
            expected_q.delete();
            pending_results <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    report_mismatch("result with no command outstanding, top_value",
                                    $signed(m_axis_tdata[31:0]), 0);
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (key_t'(m_axis_tdata[31:0]) !== want.top)
                    begin
                        report_mismatch("top_value", $signed(m_axis_tdata[31:0]), want.top);
                    end
                    if (m_axis_tdata[32] !== want.empty)
                    begin
                        report_mismatch("empty_res", m_axis_tdata[32], want.empty);
                    end
                    if (m_axis_tdata[39:33] !== want.count)
                    begin
                        report_mismatch("count", m_axis_tdata[39:33], want.count);
                    end
                    if (m_axis_tdata[41:40] !== want.status)
                    begin
                        report_mismatch("status", m_axis_tdata[41:40], want.status);
                    end
                    if (m_axis_tdata[47:42] !== 6'd0)
                    begin
                        report_mismatch("tdata padding", m_axis_tdata[47:42], 0);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                next_result = apply_command(op_t'(s_axis_tuser), key_t'(s_axis_tdata));
                expected_q.insert(expected_q.size(), next_result);
            end
            pending_results <= expected_q.size();
        end
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 1ps
// Stimulus, clock, reset and verdict for the binary min heap queue.
module testbench;
    import bmhq_pkg::*;

    localparam int TOTAL_ITEMS = 1450;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 8;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // [31:0] value
    logic [1:0]  s_axis_tuser = '0;   // [1:0] op
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [31:0] top_value, [32] empty_res, [39:33] count, [41:40] status, rest zero
    logic [47:0] m_axis_tdata;

    int error_count;
    int pending_results;
    int items_sent = 0;
    int src_idle_pct = 13;
    int dst_idle_pct = 70;
    int quiet_cycles = 0;

    binary_min_heap_queue uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    bmhq_scoreboard u_scoreboard (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= dst_idle_pct);
    end

    // Ends the run if the block stops moving transactions on both channels.
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_cmd(input op_t op, input key_t key);
        if (items_sent < TOTAL_ITEMS / 3)
        begin
            src_idle_pct = 13;
            dst_idle_pct = 70;
        end
        else if (items_sent < 2 * TOTAL_ITEMS / 3)
        begin
            src_idle_pct = 70;
            dst_idle_pct = 13;
        end
        else
        begin
            src_idle_pct = 0;
            dst_idle_pct = 0;
        end
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= key;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
    endtask

    // Keys mix the extremes, a narrow band that forces equal keys, and the full range.
    function automatic key_t pick_key();
        int sel;
        sel = $urandom_range(99);
        if (sel < 5)
        begin
            return key_t'(32'h8000_0000);
        end
        else if (sel < 10)
        begin
            return key_t'(32'h7FFF_FFFF);
        end
        else if (sel < 45)
        begin
            return key_t'($urandom_range(16) - 8);
        end
        return key_t'($urandom);
    endfunction

    // Mode 0 fills the heap, mode 1 drains it, mode 2 keeps it roughly level.
    function automatic op_t choose_op(input int mode);
        int pick;
        int push_pct;
        int pop_pct;
        pick = $urandom_range(99);
        case (mode)
            0:
            begin
                push_pct = 85;
                pop_pct  = 10;
            end
            1:
            begin
                push_pct = 15;
                pop_pct  = 81;
            end
            default:
            begin
                push_pct = 46;
                pop_pct  = 46;
            end
        endcase
        if (pick < push_pct)
        begin
            return OP_PUSH;
        end
        else if (pick < push_pct + pop_pct)
        begin
            return OP_POP;
        end
        else if (pick < push_pct + pop_pct + 2)
        begin
            return OP_CLEAR;
        end
        return OP_NOP;
    endfunction

    initial
    begin
        int mode;
        int burst;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: extremes, ties, every operation and the empty cases.
        send_cmd(OP_POP, key_t'(0));
        send_cmd(OP_PUSH, key_t'(32'h7FFF_FFFF));
        send_cmd(OP_PUSH, key_t'(32'h8000_0000));
        send_cmd(OP_PUSH, key_t'(0));
        send_cmd(OP_PUSH, key_t'(-1));
        send_cmd(OP_PUSH, key_t'(32'h8000_0000));
        send_cmd(OP_PUSH, key_t'(1));
        send_cmd(OP_PUSH, key_t'(32'h5555_5555));
        send_cmd(OP_PUSH, key_t'(32'hAAAA_AAAA));
        send_cmd(OP_NOP, key_t'(32'hFFFF_FFFF));
        send_cmd(OP_POP, key_t'(32'hFFFF_FFFF));
        send_cmd(OP_POP, key_t'(0));
        send_cmd(OP_POP, key_t'(0));
        send_cmd(OP_CLEAR, key_t'(32'h1234_5678));
        send_cmd(OP_POP, key_t'(0));
        send_cmd(OP_CLEAR, key_t'(0));
        send_cmd(OP_PUSH, key_t'(-7));
        send_cmd(OP_PUSH, key_t'(-7));
        send_cmd(OP_PUSH, key_t'(-7));
        send_cmd(OP_POP, key_t'(0));
        send_cmd(OP_POP, key_t'(0));
        send_cmd(OP_POP, key_t'(0));

        while (items_sent < TOTAL_ITEMS)
        begin
            mode  = $urandom_range(2);
            burst = $urandom_range(130, 20);
            repeat (burst)
            begin
                if (items_sent < TOTAL_ITEMS)
                begin
                    send_cmd(choose_op(mode), pick_key());
                end
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending_results != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: binary_min_heap_queue.f
hdl/bmhq_pkg.sv
hdl/bmhq_cell.sv
hdl/binary_min_heap_queue.sv
hdl/bmhq_checker.sv
verif/bmhq_checker.sv
verif/testbench.sv
